/* src/assert_macros.svh */
// Assertion helpers shared by the RTL of the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is high.
`define HHF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, but the consequent is checked in the cycle after the antecedent.
`define HHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/hhf_pkg.sv */
// ----------------------------------------------------------------------------
// hhf_pkg
// Types, codes and constants shared by the HTTP header framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hhf_pkg;

   localparam int CountBits = 16;
   localparam logic [CountBits-1:0] CountMax = '1;
   localparam logic [30:0] LengthMax = 31'h7FFF_FFFF;
   localparam logic [3:0]  KeyLength = 4'd15;

   // item opcodes
   localparam logic [1:0] OpByte  = 2'd0;
   localparam logic [1:0] OpTick  = 2'd1;
   localparam logic [1:0] OpStart = 2'd2;

   // configuration register indexes
   localparam logic [1:0] RegBufferCapacity  = 2'd0;
   localparam logic [1:0] RegMaxBodyBytes    = 2'd1;
   localparam logic [1:0] RegFirstByteTimeout = 2'd2;
   localparam logic [1:0] RegReadTimeout     = 2'd3;

   // request phase
   localparam logic [2:0] PhIdle     = 3'd0;
   localparam logic [2:0] PhWait     = 3'd1;
   localparam logic [2:0] PhHeader   = 3'd2;
   localparam logic [2:0] PhBody     = 3'd3;
   localparam logic [2:0] PhComplete = 3'd4;
   localparam logic [2:0] PhTimeout  = 3'd5;
   localparam logic [2:0] PhBad      = 3'd6;
   localparam logic [2:0] PhLarge    = 3'd7;

   // content-length value parser phase
   localparam logic [2:0] VpSearch  = 3'd0;
   localparam logic [2:0] VpSkip    = 3'd1;
   localparam logic [2:0] VpDigits  = 3'd2;
   localparam logic [2:0] VpValid   = 3'd3;
   localparam logic [2:0] VpInvalid = 3'd4;

   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [30:0] content_length;
      logic        length_invalid;
      logic [15:0] header_length;
      logic [15:0] body_count;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0]  match_position;
      logic [2:0]  value_phase;
      logic [30:0] length_value;
   } match_state_type;

   // lower-case "content-length:"
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] c;
      unique case (pos)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         4'd14:   c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/http_header_framer_unit.sv */
// ----------------------------------------------------------------------------
// http_header_framer_unit
// Frames one HTTP request: finds the header end, parses content-length,
// counts body bytes and enforces buffer, size and timeout limits.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_item  (opcode, rx_byte)
//  rsp     | out | rsp_valid/rsp_stall | rsp_item  (status, lengths, counts)
//  csr     | in  | csr_write_enable    | csr_index, csr_write_data
//
// One item per cycle while req_stall is low; each item yields one result.
// The request state is registered straight from the item and the matcher.
// An output register plus a skid register decouple the sides: req_stall is
// high only while the skid register holds a result.
// Reset (synchronous) returns to idle and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module http_header_framer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hhf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hhf_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_write_data
);
   import hhf_pkg::*;

   // configuration
   logic [15:0] capacity_ff, max_body_ff, first_timeout_ff, read_timeout_ff;

   // request state
   logic [2:0]      phase_ff, phase_in;
   match_state_type ms_ff, ms_in, ms_fed;
   logic [23:0]     last_ff, last_in;
   count_type       hc_ff, hc_in, bc_ff, bc_in;
   logic [15:0]     tc_ff, tc_in;

   // result path
   logic         rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_item_type out_ff, out_in, skid_ff, skid_in, rsp_new;

   logic         accept, pop, term;
   count_type    cap_now, hc_inc, bc_inc;
   logic [CountBits:0] buf_used;

   assign accept = req_valid && !skid_valid_ff;
   assign pop    = rsp_valid_ff && !rsp_stall;

   assign cap_now  = (32'(capacity_ff) < 32'(CountMax)) ? CountBits'(capacity_ff) : CountMax;
   assign hc_inc   = hc_ff + 1'b1;
   assign bc_inc   = bc_ff + 1'b1;
   assign buf_used = {1'b0, hc_ff} + {1'b0, bc_ff};
   assign term     = (last_ff == 24'h0D0A0D) && (req_item.rx_byte == 8'h0A);

   hhf_matcher u_matcher (
      .cur_state  (ms_ff),
      .rx_byte    (req_item.rx_byte),
      .next_state (ms_fed)
   );

   always_comb begin
      phase_in = phase_ff;
      ms_in    = ms_ff;
      last_in  = last_ff;
      hc_in    = hc_ff;
      bc_in    = bc_ff;
      tc_in    = tc_ff;
      if (accept) begin
         unique case (req_item.opcode)
            OpStart: begin
               phase_in = PhWait;
               ms_in    = '{match_position: 4'd0, value_phase: VpSearch, length_value: '0};
               last_in  = '0;
               hc_in    = '0;
               bc_in    = '0;
               tc_in    = '0;
            end
            OpByte: begin
               if (phase_ff == PhWait || phase_ff == PhHeader) begin
                  if (phase_ff == PhWait) begin
                     tc_in = '0;
                  end
                  phase_in = PhHeader;
                  ms_in    = ms_fed;
                  hc_in    = hc_inc;
                  last_in  = {last_ff[15:0], req_item.rx_byte};
                  if (term) begin
                     if (ms_fed.value_phase == VpDigits) begin
                        ms_in.value_phase = VpValid;
                     end else if (ms_fed.value_phase == VpSkip) begin
                        ms_in.value_phase = VpInvalid;
                     end
                     if (ms_in.value_phase != VpValid || ms_fed.length_value == '0) begin
                        phase_in = PhComplete;
                     end else if (ms_fed.length_value > 31'(max_body_ff)) begin
                        phase_in = PhLarge;
                     end else begin
                        phase_in = PhBody;
                        tc_in    = '0;
                        bc_in    = '0;
                     end
                  end else if (hc_inc >= cap_now) begin
                     phase_in = PhBad;
                  end
               end else if (phase_ff == PhBody) begin
                  if (buf_used >= {1'b0, cap_now}) begin
                     phase_in = PhBad;
                  end else begin
                     bc_in = bc_inc;
                     if (31'(bc_inc) >= ms_ff.length_value) begin
                        phase_in = PhComplete;
                     end
                  end
               end
            end
            OpTick: begin
               if (phase_ff == PhWait) begin
                  if (tc_ff >= first_timeout_ff) begin
                     phase_in = PhTimeout;
                  end else begin
                     tc_in = tc_ff + 16'd1;
                  end
               end else if (phase_ff == PhHeader || phase_ff == PhBody) begin
                  if ({1'b0, tc_ff} + 17'd1 >= {1'b0, read_timeout_ff}) begin
                     phase_in = PhBad;
                  end else begin
                     tc_in = tc_ff + 16'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result seen after this item
   always_comb begin
      rsp_new.status         = (phase_in >= PhComplete) ? phase_in - 3'd3 : 3'd0;
      rsp_new.content_length = (ms_in.value_phase == VpValid) ? ms_in.length_value : '0;
      rsp_new.length_invalid = (ms_in.value_phase == VpInvalid);
      rsp_new.header_length  = 16'(hc_in);
      rsp_new.body_count     = 16'(bc_in);
   end

   // output register with skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            out_in       = rsp_new;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff      <= 16'd2048;
         max_body_ff      <= 16'd1024;
         first_timeout_ff <= 16'd5000;
         read_timeout_ff  <= 16'd5000;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            RegBufferCapacity:   capacity_ff      <= csr_write_data;
            RegMaxBodyBytes:     max_body_ff      <= csr_write_data;
            RegFirstByteTimeout: first_timeout_ff <= csr_write_data;
            RegReadTimeout:      read_timeout_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhIdle;
         ms_ff         <= '{match_position: 4'd0, value_phase: VpSearch, length_value: '0};
         last_ff       <= '0;
         hc_ff         <= '0;
         bc_ff         <= '0;
         tc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         ms_ff         <= ms_in;
         last_ff       <= last_in;
         hc_ff         <= hc_in;
         bc_ff         <= bc_in;
         tc_ff         <= tc_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = out_ff;

   `HHF_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> rsp_valid_ff, "skid holds an item while output is empty")
   `HHF_ASSERT(a_body_has_length, clock, reset, (phase_ff == PhBody) |-> (ms_ff.value_phase == VpValid), "body phase without a valid length")
   `HHF_ASSERT(a_body_below_length, clock, reset, (phase_ff == PhBody) |-> (31'(bc_ff) < ms_ff.length_value), "body count reached length but not complete")
   `HHF_ASSERT_NEXT(a_blocked_to_skid, clock, reset, accept && rsp_valid_ff && rsp_stall, skid_valid_ff, "item taken while output blocked was lost")

endmodule

`default_nettype wire

/* src/hhf_matcher.sv */
// ----------------------------------------------------------------------------
// hhf_matcher
// Per-byte content-length key matcher and decimal value parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hhf_matcher (
   input  hhf_pkg::match_state_type cur_state,
   input  logic [7:0]               rx_byte,
   output hhf_pkg::match_state_type next_state
);
   import hhf_pkg::*;

   logic [7:0]  lower;
   logic        is_digit;
   logic [3:0]  digit;
   logic [34:0] times_ten;
   logic        key_hit;

   assign lower     = (rx_byte >= "A" && rx_byte <= "Z") ? rx_byte + 8'd32 : rx_byte;
   assign is_digit  = (rx_byte >= "0") && (rx_byte <= "9");
   assign digit     = rx_byte[3:0];
   // value * 10 + digit, wide enough to see a step past the 31-bit limit
   assign times_ten = 35'({cur_state.length_value, 3'b000})
                    + 35'({cur_state.length_value, 1'b0}) + 35'(digit);
   assign key_hit   = (cur_state.match_position < KeyLength)
                    && (lower == key_char(cur_state.match_position));

   always_comb begin
      next_state = cur_state;
      unique case (cur_state.value_phase)
         VpSearch: begin
            if (key_hit) begin
               if (cur_state.match_position == KeyLength - 4'd1) begin
                  next_state.value_phase    = VpSkip;
                  next_state.match_position = 4'd0;
               end else begin
                  next_state.match_position = cur_state.match_position + 4'd1;
               end
            end else begin
               next_state.match_position = (lower == key_char(4'd0)) ? 4'd1 : 4'd0;
            end
         end
         VpSkip: begin
            if (rx_byte == " " || rx_byte == 8'h09) begin
               next_state = cur_state;
            end else if (is_digit) begin
               next_state.length_value = 31'(digit);
               next_state.value_phase  = VpDigits;
            end else begin
               next_state.value_phase = VpInvalid;
            end
         end
         VpDigits: begin
            if (!is_digit) begin
               next_state.value_phase = VpValid;
            end else if (times_ten > 35'(LengthMax)) begin
               next_state.value_phase  = VpInvalid;
               next_state.length_value = '0;
            end else begin
               next_state.length_value = times_ten[30:0];
            end
         end
         default: next_state = cur_state;
      endcase
   end

endmodule

`default_nettype wire
